@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL files; indexed_list_store includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/ils_pkg.sv @@
package ils_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;

  // Port field widths are fixed.
  localparam int PORT_VAL_W = 32;
  localparam int PORT_IDX_W = 7;
  localparam int PORT_CNT_W = 7;

  localparam int POS_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (COUNT_W > PORT_IDX_W) ? COUNT_W : PORT_IDX_W;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_PEEK    = 3'd1,
    CMD_POP     = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_REPLACE = 3'd4,
    CMD_REMOVE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // What every cell does in the cycle of a command.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_WRITE  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    pos_t pos;
    val_t value;
  } bcast_t;

  function automatic val_t from_port(logic [PORT_VAL_W-1:0] v);
    val_t r;
    r = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (i < PORT_VAL_W) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [PORT_VAL_W-1:0] to_port(val_t v);
    logic [PORT_VAL_W-1:0] r;
    r = '0;
    for (int i = 0; i < PORT_VAL_W; i++) begin
      if (i < VALUE_WIDTH) r[i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ils_cell.sv @@
module ils_cell (
  input  logic          clk,
  input  ils_pkg::pos_t  my_pos,
  input  ils_pkg::bcast_t bcast,
  input  ils_pkg::val_t  prev_data,
  input  ils_pkg::val_t  next_data,
  output ils_pkg::val_t  data
);
  import ils_pkg::*;

  always_ff @(posedge clk) begin
    case (bcast.op)
      OP_INSERT: begin
        if (my_pos == bcast.pos) data <= bcast.value;
        else if (my_pos > bcast.pos) data <= prev_data;
      end
      OP_WRITE: begin
        if (my_pos == bcast.pos) data <= bcast.value;
      end
      OP_REMOVE: begin
        if (my_pos >= bcast.pos) data <= next_data;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/ils_chain.sv @@
module ils_chain (
  input  logic            clk,
  input  ils_pkg::bcast_t bcast,
  input  ils_pkg::pos_t   rd_pos,
  output ils_pkg::val_t   rd_data
);
  import ils_pkg::*;

  val_t cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    val_t prev_d;
    val_t next_d;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    ils_cell u_cell (
      .clk       (clk),
      .my_pos    (POS_W'(i)),
      .bcast     (bcast),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  // Select the tail entry: one hit at most, so OR the masked words.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (POS_W'(i) == rd_pos) rd_data = rd_data | cell_data[i];
    end
  end

endmodule

@@ rtl/core/indexed_list_store.sv @@
// Bounded ordered list of handle words held in a row of cells, one entry per
// cell. Each input item carries one command (append, peek last, pop last,
// insert at index, replace at index, remove at index) and yields exactly one
// result item with the value read, a status and the entry count after the
// command. Inserts and removes move every later entry one cell up or down in
// parallel, so an item is accepted each cycle the result register is empty
// or being drained, and its result shows in the cycle after. Failed commands
// (empty, full, index out of range) and unused command codes change nothing.
// An insert index at or past the end appends. No clearing pass runs after
// reset; entries above the count are never read.
module indexed_list_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [9:3] index, [41:10] value, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
  output logic [47:0] m_axis_tdata
);
  import ils_pkg::*;

  `include "assert_macros.svh"

  // Input fields
  logic [2:0]            cmd;
  logic [PORT_IDX_W-1:0] index;
  logic [PORT_VAL_W-1:0] value;

  assign cmd   = s_axis_tdata[2:0];
  assign index = s_axis_tdata[9:3];
  assign value = s_axis_tdata[41:10];

  // List and result registers
  count_t                count;
  count_t                count_next;
  logic [PORT_VAL_W-1:0] read_value;
  status_t               status;
  logic [PORT_CNT_W-1:0] entry_count;

  logic    s_fire;
  logic    empty;
  logic    full;
  logic    idx_in_range;
  logic    idx_past_end;
  bcast_t  bcast;
  pos_t    rd_pos;
  val_t    rd_data;
  status_t st_now;
  logic    rd_take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign empty        = (count == '0);
  assign full         = (count == COUNT_W'(CAPACITY));
  assign idx_in_range = (CMP_W'(index) < CMP_W'(count));
  assign idx_past_end = (CMP_W'(index) > CMP_W'(count));
  assign rd_pos       = POS_W'(count - COUNT_W'(1));

  // Decode the command into one broadcast to the cell row.
  always_comb begin
    bcast.op    = OP_HOLD;
    bcast.pos   = POS_W'(index);
    bcast.value = from_port(value);
    count_next  = count;
    st_now      = ST_OK;
    rd_take     = 1'b0;
    unique case (cmd) inside
      CMD_APPEND: begin
        if (full) begin
          st_now = ST_FULL;
        end else begin
          bcast.op   = OP_INSERT;
          bcast.pos  = POS_W'(count);
          count_next = count + COUNT_W'(1);
        end
      end
      CMD_PEEK, CMD_POP: begin
        if (empty) begin
          st_now = ST_EMPTY;
        end else begin
          rd_take = 1'b1;
          if (cmd == CMD_POP) count_next = count - COUNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          st_now = ST_FULL;
        end else begin
          bcast.op   = OP_INSERT;
          // Past the end: append at the tail.
          if (idx_past_end) bcast.pos = POS_W'(count);
          count_next = count + COUNT_W'(1);
        end
      end
      CMD_REPLACE: begin
        if (empty) st_now = ST_EMPTY;
        else if (!idx_in_range) st_now = ST_RANGE;
        else bcast.op = OP_WRITE;
      end
      CMD_REMOVE: begin
        if (empty) begin
          st_now = ST_EMPTY;
        end else if (!idx_in_range) begin
          st_now = ST_RANGE;
        end else begin
          bcast.op   = OP_REMOVE;
          count_next = count - COUNT_W'(1);
        end
      end
      default: begin
        // Unused codes: report ok, change nothing.
      end
    endcase
    // Drop the broadcast unless an item is actually taken this cycle.
    if (!s_fire) bcast.op = OP_HOLD;
  end

  ils_chain u_chain (
    .clk     (clk),
    .bcast   (bcast),
    .rd_pos  (rd_pos),
    .rd_data (rd_data)
  );

  // Advance the count on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_fire) begin
      count <= count_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      read_value  <= rd_take ? to_port(rd_data) : '0;
      status      <= st_now;
      entry_count <= PORT_CNT_W'(count_next);
    end
  end

  assign m_axis_tdata = {7'd0, entry_count, status, read_value};

  `ASSERT_ALWAYS(a_count_bound, rst || count <= COUNT_W'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_full_flag, s_fire && cmd == CMD_APPEND && full |=> m_axis_tvalid && status == ST_FULL && count == $past(count), "append on full not flagged")
  `ASSERT_CLK(a_pop_count, s_fire && cmd == CMD_POP && !empty |=> count == $past(count) - COUNT_W'(1), "pop did not drop count")
  `ASSERT_CLK(a_count_out, m_axis_tvalid && !rst |-> entry_count == PORT_CNT_W'(count), "reported count differs from held count")

endmodule
